### hdl/gear_shift_scheduler_top_assert.svh
// Assertion macros for the gear shift scheduler.
// GSS_ASSERT_SAME checks the consequent in the same cycle as the antecedent,
// GSS_ASSERT_NEXT checks it in the following cycle.
`ifndef GEAR_SHIFT_SCHEDULER_TOP_ASSERT_SVH
`define GEAR_SHIFT_SCHEDULER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define GSS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gear shift scheduler check failed");
`define GSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gear shift scheduler check failed");
`else
`define GSS_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define GSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### hdl/gss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gss_pkg;

    localparam int MUL_A_W = 26;
    localparam int MUL_B_W = 25;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    typedef logic [MUL_A_W-1:0] t_mul_a;
    typedef logic [MUL_B_W-1:0] t_mul_b;
    typedef logic [PROD_W-1:0]  t_prod;

    // register indexes of the configuration port
    localparam logic [1:0] CFG_IDLE_RPM   = 2'd0;
    localparam logic [1:0] CFG_REDLINE    = 2'd1;
    localparam logic [1:0] CFG_HOLD_TIME  = 2'd2;

    // schedule constants, rpm in Q14.10
    localparam logic [22:0] UP_BASE   = 23'd2662400;
    localparam logic [22:0] DOWN_BASE = 23'd1331200;
    localparam logic [6:0]  UP_SLOPE  = 7'd125;
    localparam logic [10:0] DOWN_SLOPE = 11'd1900;
    localparam logic [6:0]  HYST_UP   = 7'd92;
    localparam logic [6:0]  HYST_LOW  = 7'd100;
    localparam logic [11:0] SLIP_GAIN = 12'd2600;

    // wheel speed to engine rpm, Q16, per gear
    function automatic t_mul_b gss_coef(input logic [3:0] idx);
        t_mul_b c;
        case (idx)
            4'd1:    c = 25'd23155440;
            4'd2:    c = 25'd15086120;
            4'd3:    c = 25'd10876040;
            4'd4:    c = 25'd8279824;
            4'd5:    c = 25'd6595792;
            4'd6:    c = 25'd5473104;
            4'd7:    c = 25'd4631088;
            4'd8:    c = 25'd3929408;
            default: c = 25'd0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

### hdl/gss_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module gss_mul (
    input  wire logic           i_clk,
    input  wire logic           i_en,
    input  wire gss_pkg::t_mul_a i_a,
    input  wire gss_pkg::t_mul_b i_b,
    output gss_pkg::t_prod      o_prod
);
    import gss_pkg::*;

    t_prod r_prod;

    // hold the product until the next operand pair is issued
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

### hdl/gear_shift_scheduler_top.sv
`timescale 1ns / 1ps
`default_nettype none
`include "gear_shift_scheduler_top_assert.svh"
// Gear shift scheduler: one tick in, one result out.
// Input channel: i_in_valid with o_in_stall; a tick is taken at a rising edge
// with i_in_valid high and o_in_stall low. Payload is forward speed, throttle,
// reverse request and tick length.
// Output channel: o_out_valid with i_out_stall; a beat moves at a rising edge
// with o_out_valid high and i_out_stall low. Payload is gear, engine speed and
// the shift flag.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 idle rpm, 1 redline rpm, 2 shift hold time); write only while idle.
// The sequencer walks 13 steps from the accepted tick to the registered result,
// eleven of them on the one shared 26x25 multiplier; a new tick is taken only
// once the sequencer is back in idle.
// o_in_stall is high while the sequencer works and during reset.
// If the receiver stalls, the result beat holds; a finished next tick waits in
// its last step until the output register frees.
// Reset (synchronous, active low) clears gear, timers and smoothed values and
// loads the default configuration.
module gear_shift_scheduler_top #(
    parameter int TOP_GEAR = 6
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic signed [15:0] i_forward_speed,
    input  wire logic [10:0] i_throttle_level,
    input  wire logic        i_reverse_request,
    input  wire logic [15:0] i_tick_length,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic signed [3:0] o_gear_now,
    output logic [13:0]      o_engine_speed,
    output logic             o_shift_event,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);
    import gss_pkg::*;

    localparam int TOP_G = (TOP_GEAR > 8) ? 8 : ((TOP_GEAR < 1) ? 1 : TOP_GEAR);
    localparam logic signed [4:0] TOP_G5 = 5'(TOP_G);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_THR  = 4'd1;
    localparam logic [3:0] ST_THU  = 4'd2;
    localparam logic [3:0] ST_CUR  = 4'd3;
    localparam logic [3:0] ST_UPP  = 4'd4;
    localparam logic [3:0] ST_DNP  = 4'd5;
    localparam logic [3:0] ST_LOW  = 4'd6;
    localparam logic [3:0] ST_U92  = 4'd7;
    localparam logic [3:0] ST_DEC  = 4'd8;
    localparam logic [3:0] ST_SL1  = 4'd9;
    localparam logic [3:0] ST_SL2  = 4'd10;
    localparam logic [3:0] ST_TGT  = 4'd11;
    localparam logic [3:0] ST_RPM  = 4'd12;
    localparam logic [3:0] ST_FIN  = 4'd13;

    function automatic logic [3:0] f_gear_idx(input logic signed [4:0] g);
        logic [3:0] idx;
        if (g < 5'sd1) begin
            idx = 4'd1;
        end else if (g > TOP_G5) begin
            idx = 4'(TOP_G);
        end else begin
            idx = g[3:0];
        end
        return idx;
    endfunction

    logic [3:0]  r_state;
    logic [11:0] r_idle_rpm;
    logic [13:0] r_redline;
    logic [15:0] r_hold_time;

    logic signed [4:0] r_gear;
    logic [15:0] r_ts;
    logic [15:0] r_hold;
    logic [23:0] r_rs;

    logic [15:0] r_v;
    logic [10:0] r_thr;
    logic        r_fwd;
    logic [15:0] r_dt;
    logic        r_shifted;

    logic [25:0] r_cur;
    logic [22:0] r_up;
    logic [22:0] r_down;
    logic [25:0] r_lo;
    logic [29:0] r_up92;
    logic [22:0] r_slip;
    logic [23:0] r_tgt;

    logic        r_out_valid;
    logic [3:0]  r_gear_out;
    logic [13:0] r_eng_out;
    logic        r_shift_out;

    logic        accept;
    logic        out_free;
    logic        mul_en;
    t_mul_a      mul_a;
    t_mul_b      mul_b;
    t_prod       prod;

    logic [15:0] thr_tgt;
    logic        thr_rise;
    logic [15:0] thr_diff;
    logic [16:0] a_thr;
    logic [19:0] dt12;
    logic [16:0] a_rpm;
    logic        rpm_rise;
    logic [23:0] rpm_diff;
    logic [11:0] vc;
    logic [11:0] slip_span;
    logic [25:0] tgt_raw;
    logic [25:0] tgt_floor;
    logic [25:0] cap;
    logic [23:0] rs_new;
    logic [15:0] ts_new;

    logic [15:0] in_v;
    logic [10:0] in_thr;
    logic        in_rev;

    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // input conditioning
    always_comb begin
        in_v   = i_forward_speed[15] ? 16'(~i_forward_speed + 16'sd1)
                                     : 16'(i_forward_speed);
        in_thr = (i_throttle_level > 11'd1024) ? 11'd1024 : i_throttle_level;
        in_rev = i_reverse_request || (i_forward_speed < -16'sd128);
    end

    // blend factors and differences
    always_comb begin
        thr_tgt  = {r_thr[10:0], 5'b0};
        thr_rise = thr_tgt >= r_ts;
        thr_diff = thr_rise ? (thr_tgt - r_ts) : (r_ts - thr_tgt);
        a_thr    = ({r_dt, 1'b0} > 17'd65536) ? 17'd65536 : {r_dt, 1'b0};
        dt12     = {1'b0, r_dt, 3'b0} + {2'b0, r_dt, 2'b0};
        a_rpm    = (dt12 > 20'd65536) ? 17'd65536 : dt12[16:0];
        rpm_rise = r_tgt >= r_rs;
        rpm_diff = rpm_rise ? (r_tgt - r_rs) : (r_rs - r_tgt);
        vc       = (r_v > 16'd2048) ? 12'd2048 : r_v[11:0];
        slip_span = 12'd2048 - vc;
        tgt_raw  = prod[39:14];
        tgt_floor = (tgt_raw < 26'(r_slip)) ? 26'(r_slip) : tgt_raw;
        cap      = {2'b0, r_redline, 10'b0};
        ts_new   = thr_rise ? (r_ts + prod[31:16]) : (r_ts - prod[31:16]);
        rs_new   = rpm_rise ? (r_rs + prod[39:16]) : (r_rs - prod[39:16]);
    end

    // operand select for the shared multiplier
    always_comb begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (r_state)
            ST_THR: begin
                mul_a = MUL_A_W'(thr_diff);
                mul_b = MUL_B_W'(a_thr);
            end
            ST_THU: begin
                mul_a = MUL_A_W'(r_v);
                mul_b = gss_coef(f_gear_idx(r_gear));
            end
            ST_CUR: begin
                mul_a = MUL_A_W'(r_ts);
                mul_b = MUL_B_W'(UP_SLOPE);
            end
            ST_UPP: begin
                mul_a = MUL_A_W'(r_ts);
                mul_b = MUL_B_W'(DOWN_SLOPE);
            end
            ST_DNP: begin
                mul_a = MUL_A_W'(r_v);
                mul_b = gss_coef(f_gear_idx(r_gear - 5'sd1));
            end
            ST_LOW: begin
                mul_a = MUL_A_W'(r_up);
                mul_b = MUL_B_W'(HYST_UP);
            end
            ST_U92: begin
                mul_a = r_lo;
                mul_b = MUL_B_W'(HYST_LOW);
            end
            ST_DEC: begin
                mul_a = MUL_A_W'(r_thr);
                mul_b = MUL_B_W'(SLIP_GAIN);
            end
            ST_SL1: begin
                mul_a = MUL_A_W'(prod[21:0]);
                mul_b = MUL_B_W'(slip_span);
            end
            ST_SL2: begin
                mul_a = MUL_A_W'(r_v);
                mul_b = gss_coef(f_gear_idx(r_gear));
            end
            ST_RPM: begin
                mul_a = MUL_A_W'(rpm_diff);
                mul_b = MUL_B_W'(a_rpm);
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    gss_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_rpm  <= 12'd900;
            r_redline   <= 14'd7200;
            r_hold_time <= 16'd26214;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IDLE_RPM:  r_idle_rpm  <= i_cfg_data[11:0];
                CFG_REDLINE:   r_redline   <= i_cfg_data[13:0];
                CFG_HOLD_TIME: r_hold_time <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // sequencer and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_gear      <= '0;
            r_ts        <= '0;
            r_hold      <= '0;
            r_rs        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && r_state != ST_FIN) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= ST_THR;
                    end
                end
                ST_THR: r_state <= ST_THU;
                ST_THU: begin
                    if (r_fwd) begin
                        r_ts   <= ts_new;
                        r_hold <= (r_hold > r_dt) ? (r_hold - r_dt) : 16'd0;
                    end
                    r_state <= ST_CUR;
                end
                ST_CUR: r_state <= ST_UPP;
                ST_UPP: r_state <= ST_DNP;
                ST_DNP: r_state <= ST_LOW;
                ST_LOW: r_state <= ST_U92;
                ST_U92: r_state <= ST_DEC;
                ST_DEC: begin
                    if (r_fwd && r_hold == 16'd0) begin
                        if (r_gear < TOP_G5 && 26'(r_up) < r_cur) begin
                            r_gear <= r_gear + 5'sd1;
                            r_hold <= r_hold_time;
                        end else if (r_gear > 5'sd1 && r_cur < 26'(r_down) &&
                                     prod < PROD_W'(r_up92)) begin
                            r_gear <= r_gear - 5'sd1;
                            r_hold <= r_hold_time;
                        end
                    end
                    r_state <= ST_SL1;
                end
                ST_SL1: r_state <= ST_SL2;
                ST_SL2: r_state <= ST_TGT;
                ST_TGT: r_state <= ST_RPM;
                ST_RPM: r_state <= ST_FIN;
                ST_FIN: begin
                    // hold here until the output register frees
                    if (out_free) begin
                        r_rs        <= rs_new;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            // gear select happens on the accepted beat
            if (r_state == ST_IDLE && accept) begin
                if (in_rev) begin
                    r_gear <= -5'sd1;
                end else if (r_gear < 5'sd1) begin
                    r_gear <= 5'sd1;
                end else if (r_gear > TOP_G5) begin
                    r_gear <= TOP_G5;
                end
            end
        end
    end

    // per-tick working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_v       <= in_v;
                    r_thr     <= in_thr;
                    r_fwd     <= !in_rev;
                    r_dt      <= i_tick_length;
                    r_shifted <= 1'b0;
                end
            end
            ST_CUR: r_cur  <= prod[39:14];
            ST_UPP: r_up   <= UP_BASE + prod[22:0];
            ST_DNP: r_down <= DOWN_BASE + 23'(prod[25:5]);
            ST_LOW: r_lo   <= prod[39:14];
            ST_U92: r_up92 <= prod[29:0];
            ST_DEC: begin
                if (r_fwd && r_hold == 16'd0) begin
                    if (r_gear < TOP_G5 && 26'(r_up) < r_cur) begin
                        r_shifted <= 1'b1;
                    end else if (r_gear > 5'sd1 && r_cur < 26'(r_down) &&
                                 prod < PROD_W'(r_up92)) begin
                        r_shifted <= 1'b1;
                    end
                end
            end
            ST_SL2: r_slip <= {r_idle_rpm, 10'b0} + 23'(prod[33:11]);
            ST_TGT: r_tgt  <= (tgt_floor > cap) ? cap[23:0] : tgt_floor[23:0];
            ST_FIN: begin
                if (out_free) begin
                    r_gear_out  <= r_gear[3:0];
                    r_eng_out   <= rs_new[23:10];
                    r_shift_out <= r_shifted;
                end
            end
            default: ;
        endcase
    end

    assign o_in_stall     = (r_state != ST_IDLE) || !i_rst_n;
    assign o_out_valid    = r_out_valid;
    assign o_gear_now     = r_gear_out;
    assign o_engine_speed = r_eng_out;
    assign o_shift_event  = r_shift_out;

    `GSS_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, accept, r_state == ST_THR)
    `GSS_ASSERT_SAME(a_gear_range, i_clk, i_rst_n, o_out_valid, (r_gear_out == 4'hF) || (r_gear_out != 4'h0 && r_gear_out <= 4'(TOP_G)))
    `GSS_ASSERT_SAME(a_shift_forward, i_clk, i_rst_n, o_out_valid && o_shift_event, r_gear_out != 4'hF)
    `GSS_ASSERT_SAME(a_shift_rearms, i_clk, i_rst_n, r_state == ST_SL1 && r_shifted, r_hold == r_hold_time)

endmodule

`default_nettype wire

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import gss_pkg::*;

    localparam int TOP_GEAR    = 6;
    localparam int CYCLE_LIMIT = 300000;
    localparam int NUM_ROWS    = 20;
    localparam int PHASE_TICKS = 90;

    typedef struct packed {
        logic signed [3:0] gear;
        logic [13:0]       rpm;
        logic              shift;
    } t_drive_result;

    typedef struct packed {
        logic signed [15:0] speed;
        logic [10:0]        thr;
        logic               rev;
        logic [15:0]        dt;
        logic               typed;
        t_drive_result      want;
    } t_tick_row;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic signed [15:0] in_speed = '0;
    logic [10:0] in_thr = '0;
    logic in_rev = 1'b0;
    logic [15:0] in_dt = '0;
    logic out_stall = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_idx = CFG_IDLE_RPM;
    logic [15:0] cfg_data = '0;

    wire o_in_stall;
    wire o_out_valid;
    wire signed [3:0] o_gear_now;
    wire [13:0] o_engine_speed;
    wire o_shift_event;

    gear_shift_scheduler_top #(.TOP_GEAR(TOP_GEAR)) u_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (o_in_stall),
        .i_forward_speed  (in_speed),
        .i_throttle_level (in_thr),
        .i_reverse_request(in_rev),
        .i_tick_length    (in_dt),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (out_stall),
        .o_gear_now       (o_gear_now),
        .o_engine_speed   (o_engine_speed),
        .o_shift_event    (o_shift_event),
        .i_cfg_we         (cfg_we),
        .i_cfg_idx        (cfg_idx),
        .i_cfg_data       (cfg_data)
    );

    // gearbox shadow state and register copies
    int          gear_st = 0;
    logic [31:0] thr_s = '0;
    logic [31:0] hold_st = '0;
    logic [31:0] rpm_s = '0;
    logic [11:0] idle_cfg = 12'd900;
    logic [13:0] redline_cfg = 14'd7200;
    logic [15:0] hold_cfg = 16'd26214;

    t_drive_result pending_results[$];
    t_tick_row directed_ticks [NUM_ROWS];

    logic calm = 1'b0;
    int mismatches = 0;
    int ticks_sent = 0;
    int results_seen = 0;
    int shifts_seen = 0;
    int reverse_seen = 0;
    logic [15:0] gears_hit = '0;
    int cycles = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    // wheel speed (Q7.8 magnitude) to engine rpm in Q14.10 at gear g
    function automatic logic [31:0] wheel_to_rpm(input logic [16:0] v, input int g);
        logic [63:0] coef;
        int gg;
        gg = g;
        if (gg < 1) gg = 1;
        if (gg > TOP_GEAR) gg = TOP_GEAR;
        case (gg)
            1: coef = 64'd23155440;
            2: coef = 64'd15086120;
            3: coef = 64'd10876040;
            4: coef = 64'd8279824;
            5: coef = 64'd6595792;
            6: coef = 64'd5473104;
            7: coef = 64'd4631088;
            8: coef = 64'd3929408;
            default: coef = 64'd0;
        endcase
        return 32'((64'(v) * coef) >> 14);
    endfunction

    // move cur toward tgt by fraction a (Q0.16), step truncated toward zero
    function automatic logic [31:0] ease(input logic [31:0] cur, input logic [31:0] tgt,
                                         input int a);
        if (tgt >= cur)
            return cur + 32'((64'(tgt - cur) * 64'(a)) >> 16);
        return cur - 32'((64'(cur - tgt) * 64'(a)) >> 16);
    endfunction

    task automatic predict_tick(input logic signed [15:0] speed, input logic [10:0] thr_in,
                                input logic rev, input logic [15:0] dt,
                                output t_drive_result res);
        int spd;
        int ta;
        logic [16:0] v;
        logic [16:0] vc;
        logic [10:0] thr;
        logic [31:0] up;
        logic [31:0] down;
        logic [31:0] cur;
        logic [31:0] target;
        logic [31:0] slip;
        logic [31:0] cap;
        logic shifted;
        spd = speed;
        v = 17'(spd < 0 ? -spd : spd);
        thr = (thr_in > 11'd1024) ? 11'd1024 : thr_in;
        shifted = 1'b0;
        if (rev || spd < -128) begin
            gear_st = -1;
        end else begin
            if (gear_st < 1) gear_st = 1;
            if (gear_st > TOP_GEAR) gear_st = TOP_GEAR;
            ta = int'(dt) * 2;
            if (ta > 65536) ta = 65536;
            thr_s = ease(thr_s, 32'(thr) << 5, ta);
            up = 32'd2662400 + thr_s * 32'd125;
            down = 32'd1331200 + ((thr_s * 32'd1900) >> 5);
            hold_st = (hold_st > 32'(dt)) ? hold_st - 32'(dt) : 32'd0;
            if (hold_st == 0) begin
                cur = wheel_to_rpm(v, gear_st);
                if (gear_st < TOP_GEAR && cur > up) begin
                    gear_st++;
                    hold_st = 32'(hold_cfg);
                    shifted = 1'b1;
                end else if (gear_st > 1 && cur < down &&
                             64'(wheel_to_rpm(v, gear_st - 1)) * 100 < 64'(up) * 92) begin
                    gear_st--;
                    hold_st = 32'(hold_cfg);
                    shifted = 1'b1;
                end
            end
        end
        target = wheel_to_rpm(v, gear_st < 0 ? 1 : gear_st);
        vc = (v > 17'd2048) ? 17'd2048 : v;
        slip = (32'(idle_cfg) << 10) + 32'((64'(thr) * 64'd2600 * 64'(17'd2048 - vc)) >> 11);
        if (target < slip) target = slip;
        cap = 32'(redline_cfg) << 10;
        if (target > cap) target = cap;
        ta = int'(dt) * 12;
        if (ta > 65536) ta = 65536;
        rpm_s = ease(rpm_s, target, ta) & 32'hFFFFFF;
        res.gear = 4'(gear_st);
        res.rpm = 14'(rpm_s >> 10);
        res.shift = shifted;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        case (idx)
            CFG_IDLE_RPM:  idle_cfg = val[11:0];
            CFG_REDLINE:   redline_cfg = val[13:0];
            CFG_HOLD_TIME: hold_cfg = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_tick(input logic signed [15:0] speed, input logic [10:0] thr,
                             input logic rev, input logic [15:0] dt,
                             input logic typed, input t_drive_result want);
        int gap;
        int r;
        t_drive_result res;
        r = $urandom_range(0, 99);
        if (calm || r < 60) gap = 0;
        else if (r < 92) gap = $urandom_range(1, 3);
        else gap = $urandom_range(12, 40);
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_speed <= speed;
        in_thr <= thr;
        in_rev <= rev;
        in_dt <= dt;
        do @(posedge clk); while (o_in_stall);
        predict_tick(speed, thr, rev, dt, res);
        pending_results.push_back(typed ? want : res);
        ticks_sent++;
    endtask

    // drop valid, let every result come home, then let the pipeline settle
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    // receiver: runs of ready beats broken by stalls of random length; never stalls while calm
    initial begin
        int len;
        logic val;
        forever begin
            if (calm) begin
                val = 1'b0;
                len = 1;
            end else if (out_stall) begin
                val = 1'b0;
                len = $urandom_range(1, 12);
            end else begin
                val = 1'b1;
                len = ($urandom_range(0, 99) < 75) ? $urandom_range(1, 3)
                                                   : $urandom_range(16, 50);
            end
            @(negedge clk);
            out_stall <= val;
            repeat (len - 1) @(negedge clk);
        end
    end

    always @(posedge clk) begin : check_results
        t_drive_result want;
        if (rst_n && o_out_valid && !out_stall) begin
            results_seen++;
            if (o_shift_event) shifts_seen++;
            if (o_gear_now == -4'sd1) reverse_seen++;
            gears_hit[4'(o_gear_now + 4'sd1)] <= 1'b1;
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected beat, gear %0d rpm %0d shift %0d", $time,
                         o_gear_now, o_engine_speed, o_shift_event);
            end else begin
                want = pending_results.pop_front();
                if (o_gear_now !== want.gear) begin
                    mismatches++;
                    $display("%0t: gear_now expected %0d, got %0d", $time,
                             want.gear, o_gear_now);
                end
                if (o_engine_speed !== want.rpm) begin
                    mismatches++;
                    $display("%0t: engine_speed expected %0d, got %0d", $time,
                             want.rpm, o_engine_speed);
                end
                if (o_shift_event !== want.shift) begin
                    mismatches++;
                    $display("%0t: shift_event expected %0d, got %0d", $time,
                             want.shift, o_shift_event);
                end
            end
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int cruise;
        int heading;
        int pedal;
        int r;
        logic signed [15:0] speed;
        logic [10:0] thr;
        logic rev;
        logic [15:0] dt;
        logic [15:0] idle_val;
        logic [15:0] red_val;
        logic [15:0] hold_val;

        // speed, throttle, reverse, tick, typed, expected beat
        directed_ticks[0]  = '{16'sd0, 11'd0, 1'b0, 16'd0, 1'b1, '{4'sd1, 14'd0, 1'b0}};
        directed_ticks[1]  = '{16'sd0, 11'd0, 1'b0, 16'd65535, 1'b1, '{4'sd1, 14'd900, 1'b0}};
        directed_ticks[2]  = '{16'sd0, 11'd2047, 1'b0, 16'd65535, 1'b1,
                               '{4'sd1, 14'd3500, 1'b0}};
        directed_ticks[3]  = '{16'sd0, 11'd0, 1'b1, 16'd65535, 1'b1,
                               '{-4'sd1, 14'd900, 1'b0}};
        directed_ticks[4]  = '{-16'sd32768, 11'd0, 1'b0, 16'd0, 1'b1,
                               '{-4'sd1, 14'd900, 1'b0}};
        directed_ticks[5]  = '{16'sd0, 11'd0, 1'b0, 16'd0, 1'b1, '{4'sd1, 14'd900, 1'b0}};
        directed_ticks[6]  = '{16'sd32767, 11'd0, 1'b0, 16'd65535, 1'b1,
                               '{4'sd2, 14'd7200, 1'b1}};
        directed_ticks[7]  = '{16'sd32767, 11'd0, 1'b0, 16'd1, 1'b0, '0};
        directed_ticks[8]  = '{-16'sd128, 11'd500, 1'b0, 16'd3000, 1'b0, '0};
        directed_ticks[9]  = '{-16'sd129, 11'd500, 1'b0, 16'd3000, 1'b0, '0};
        directed_ticks[10] = '{16'sd2560, 11'd1024, 1'b0, 16'd1638, 1'b0, '0};
        directed_ticks[11] = '{16'sd2560, 11'd1024, 1'b0, 16'd65535, 1'b0, '0};
        directed_ticks[12] = '{16'sd5000, 11'd300, 1'b0, 16'd65535, 1'b0, '0};
        directed_ticks[13] = '{16'sd20000, 11'd800, 1'b0, 16'd65535, 1'b0, '0};
        directed_ticks[14] = '{16'sd20000, 11'd800, 1'b0, 16'd65535, 1'b0, '0};
        directed_ticks[15] = '{16'sd1000, 11'd0, 1'b0, 16'd65535, 1'b0, '0};
        directed_ticks[16] = '{16'sd1000, 11'd0, 1'b0, 16'd65535, 1'b0, '0};
        directed_ticks[17] = '{16'sd32767, 11'd1024, 1'b1, 16'd0, 1'b0, '0};
        directed_ticks[18] = '{16'sd0, 11'd1025, 1'b0, 16'd32768, 1'b0, '0};
        directed_ticks[19] = '{16'sd1, 11'd1, 1'b0, 16'd65535, 1'b0, '0};

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_ROWS; i++)
            send_tick(directed_ticks[i].speed, directed_ticks[i].thr, directed_ticks[i].rev,
                      directed_ticks[i].dt, directed_ticks[i].typed, directed_ticks[i].want);
        drain_results();

        cruise = 0;
        heading = 1;
        pedal = 400;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin idle_val = 16'd900;  red_val = 16'd7200;  hold_val = 16'd26214; end
                1: begin idle_val = 16'd800;  red_val = 16'd6500;  hold_val = 16'd0;     end
                // idle above redline, longest hold-off
                2: begin idle_val = 16'd4095; red_val = 16'd1000;  hold_val = 16'd65535; end
                3: begin idle_val = 16'd0;    red_val = 16'd16383; hold_val = 16'd1;     end
                default: begin
                    idle_val = 16'($urandom_range(0, 4095));
                    red_val = 16'($urandom_range(1000, 16383));
                    hold_val = 16'($urandom_range(0, 40000));
                end
            endcase
            calm = (phase == 5);
            write_reg(CFG_IDLE_RPM, idle_val);
            write_reg(CFG_REDLINE, red_val);
            write_reg(CFG_HOLD_TIME, hold_val);

            for (int n = 0; n < PHASE_TICKS; n++) begin
                if (n == PHASE_TICKS / 2) drain_results();
                r = $urandom_range(0, 99);
                if (r < 75) begin
                    // plausible drive cycle: speed wanders up and down through the gears
                    if ($urandom_range(0, 99) < 4) heading = -heading;
                    cruise += heading * int'($urandom_range(0, 300))
                              + int'($urandom_range(0, 100)) - 50;
                    if (cruise > 22000) begin cruise = 22000; heading = -1; end
                    if (cruise < -300) begin cruise = -300; heading = 1; end
                    pedal += int'($urandom_range(0, 240)) - 120;
                    if (pedal < 0) pedal = 0;
                    if (pedal > 1100) pedal = 1100;
                    speed = 16'(cruise);
                    thr = 11'(pedal);
                    rev = ($urandom_range(0, 49) == 0);
                    dt = 16'($urandom_range(600, 4000));
                end else if (r < 90) begin
                    speed = 16'($urandom);
                    thr = 11'($urandom);
                    rev = 1'($urandom);
                    dt = 16'($urandom);
                end else begin
                    case ($urandom_range(0, 5))
                        0: speed = -16'sd129;
                        1: speed = -16'sd128;
                        2: speed = -16'sd127;
                        3: speed = 16'sd0;
                        4: speed = 16'sd32767;
                        default: speed = -16'sd32768;
                    endcase
                    case ($urandom_range(0, 3))
                        0: thr = 11'd0;
                        1: thr = 11'd1024;
                        2: thr = 11'd1025;
                        default: thr = 11'd2047;
                    endcase
                    case ($urandom_range(0, 4))
                        0: dt = 16'd0;
                        1: dt = 16'd1;
                        2: dt = 16'd32767;
                        3: dt = 16'd32768;
                        default: dt = 16'd65535;
                    endcase
                    rev = 1'($urandom);
                end
                send_tick(speed, thr, rev, dt, 1'b0, '0);
            end
            drain_results();
        end

        $display("Covered %0d ticks over six register settings: %0d beats, %0d shifts,",
                 ticks_sent, results_seen, shifts_seen);
        $display("%0d reverse beats, gear mask (reverse at bit 0) %b, %0d mismatches",
                 reverse_seen, gears_hit, mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
